// ===== rtl/mant_pkg.sv =====
`timescale 1ns / 1ps
// shared types, message constants and the control store of the note tracker
// no dependencies; imported by mant_seq, mant_dp and the top level
package mant_pkg;

  localparam int TDATA_W = 24;
  localparam int STEP_W  = 4;

  localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
  localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
  localparam logic [3:0] TYPE_PROGRAM  = 4'hc;
  localparam logic [3:0] TYPE_PRESSURE = 4'hd;
  localparam logic [1:0] LEN_SHORT     = 2'd2;
  localparam logic [1:0] LEN_FULL      = 2'd3;

  // program step codes
  localparam logic [STEP_W-1:0] S_IDLE     = 4'd0;
  localparam logic [STEP_W-1:0] S_DISP_CUT = 4'd1;
  localparam logic [STEP_W-1:0] S_DISP_ON  = 4'd2;
  localparam logic [STEP_W-1:0] S_DISP_OFF = 4'd3;
  localparam logic [STEP_W-1:0] S_PASS     = 4'd4;
  localparam logic [STEP_W-1:0] S_ON_FULL  = 4'd5;
  localparam logic [STEP_W-1:0] S_ON_TEST  = 4'd6;
  localparam logic [STEP_W-1:0] S_OFF_RD   = 4'd7;
  localparam logic [STEP_W-1:0] S_OFF_CMP  = 4'd8;
  localparam logic [STEP_W-1:0] S_CUT_CHK  = 4'd9;
  localparam logic [STEP_W-1:0] S_CUT_TEST = 4'd10;
  localparam logic [STEP_W-1:0] S_CUT_EMIT = 4'd11;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_IN_VALID,
    C_IS_CUT,
    C_IS_ON,
    C_IS_OFF,
    C_OUT_FREE,
    C_FULL,
    C_SLOT_FREE,
    C_SLOT_BUSY,
    C_IDX_END,
    C_MATCH,
    C_NONE_BUSY
  } cond_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_EMIT_PASS,
    ACT_SET_OVF,
    ACT_TAKE,
    ACT_OFF_CMP,
    ACT_SCAN,
    ACT_EMIT_OFF
  } act_e;

  typedef struct packed {
    cond_e             cond;
    act_e              act;
    logic [STEP_W-1:0] jump_true;
    logic [STEP_W-1:0] jump_false;
  } ucode_t;

  typedef struct packed {
    act_e act;
    logic cond_ok;
    logic in_ready;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic is_cut;
    logic is_on;
    logic is_off;
    logic out_free;
    logic full;
    logic slot_free;
    logic slot_busy;
    logic idx_end;
    logic match;
    logic none_busy;
  } status_t;

  typedef struct packed {
    logic       mode;
    logic [3:0] msg_type;
    logic [3:0] msg_channel;
    logic [6:0] data_one;
    logic [6:0] data_two;
  } item_t;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [6:0] out_data_one;
    logic [6:0] out_data_two;
    logic [1:0] msg_length;
    logic       table_overflow;
    logic       last_result;
  } result_t;

  typedef struct packed {
    logic [3:0] chan;
    logic [6:0] note;
  } slot_entry_t;

  // control store
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    unique case (step)
      S_IDLE:     w = '{C_IN_VALID,  ACT_LOAD,      S_DISP_CUT, S_IDLE};
      S_DISP_CUT: w = '{C_IS_CUT,    ACT_NONE,      S_CUT_CHK,  S_DISP_ON};
      S_DISP_ON:  w = '{C_IS_ON,     ACT_NONE,      S_ON_FULL,  S_DISP_OFF};
      S_DISP_OFF: w = '{C_IS_OFF,    ACT_NONE,      S_OFF_RD,   S_PASS};
      S_PASS:     w = '{C_OUT_FREE,  ACT_EMIT_PASS, S_IDLE,     S_PASS};
      S_ON_FULL:  w = '{C_FULL,      ACT_SET_OVF,   S_PASS,     S_ON_TEST};
      S_ON_TEST:  w = '{C_SLOT_FREE, ACT_TAKE,      S_PASS,     S_ON_TEST};
      S_OFF_RD:   w = '{C_IDX_END,   ACT_NONE,      S_PASS,     S_OFF_CMP};
      S_OFF_CMP:  w = '{C_MATCH,     ACT_OFF_CMP,   S_PASS,     S_OFF_RD};
      S_CUT_CHK:  w = '{C_NONE_BUSY, ACT_NONE,      S_IDLE,     S_CUT_TEST};
      S_CUT_TEST: w = '{C_SLOT_BUSY, ACT_SCAN,      S_CUT_EMIT, S_CUT_TEST};
      S_CUT_EMIT: w = '{C_OUT_FREE,  ACT_EMIT_OFF,  S_CUT_CHK,  S_CUT_EMIT};
      default:    w = '{C_ALWAYS,    ACT_NONE,      S_IDLE,     S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/mant_seq.sv =====
`timescale 1ns / 1ps
// microprogram sequencer: step counter, control store lookup, condition select
// depends on mant_pkg
module mant_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mant_pkg::status_t status_i,
  output mant_pkg::ctrl_t   ctrl_o
);
  import mant_pkg::*;

  logic [STEP_W-1:0] upc_q, upc_d;
  ucode_t            word;
  logic              cond_ok;

  assign word = ucode_rom(upc_q);

  always_comb begin
    unique case (word.cond)
      C_ALWAYS:    cond_ok = 1'b1;
      C_IN_VALID:  cond_ok = status_i.in_valid;
      C_IS_CUT:    cond_ok = status_i.is_cut;
      C_IS_ON:     cond_ok = status_i.is_on;
      C_IS_OFF:    cond_ok = status_i.is_off;
      C_OUT_FREE:  cond_ok = status_i.out_free;
      C_FULL:      cond_ok = status_i.full;
      C_SLOT_FREE: cond_ok = status_i.slot_free;
      C_SLOT_BUSY: cond_ok = status_i.slot_busy;
      C_IDX_END:   cond_ok = status_i.idx_end;
      C_MATCH:     cond_ok = status_i.match;
      C_NONE_BUSY: cond_ok = status_i.none_busy;
      default:     cond_ok = 1'b0;
    endcase
  end

  assign upc_d = cond_ok ? word.jump_true : word.jump_false;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= S_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctrl_o.act      = word.act;
  assign ctrl_o.cond_ok  = cond_ok;
  assign ctrl_o.in_ready = (upc_q == S_IDLE);

endmodule

// ===== rtl/mant_dp.sv =====
`timescale 1ns / 1ps
// datapath: held message, slot memory, busy bits, scan index, result register
// depends on mant_pkg; driven by mant_seq
module mant_dp #(
  parameter int SLOT_COUNT = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mant_pkg::ctrl_t   ctrl_i,
  input  logic              in_valid_i,
  input  mant_pkg::item_t   item_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output mant_pkg::result_t result_o,
  output mant_pkg::status_t status_o
);
  import mant_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  item_t                 item_q;
  logic                  ovf_q, ovf_d;
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [SLOT_COUNT-1:0] busy_q, busy_d;
  slot_entry_t           slot_mem_q [SLOT_COUNT];
  slot_entry_t           rd_q;
  logic                  out_valid_q, out_valid_d;
  result_t               out_q, out_d;

  logic [IDX_W-1:0]      idx;
  logic                  out_free;
  logic                  fire;
  logic                  load_fire, take_fire, emit_off_fire;

  assign idx      = idx_q[IDX_W-1:0];
  assign out_free = !out_valid_q || out_ready_i;
  assign fire     = ctrl_i.cond_ok;

  assign load_fire      = (ctrl_i.act == ACT_LOAD) && fire;
  assign take_fire      = (ctrl_i.act == ACT_TAKE) && fire;
  assign emit_off_fire  = (ctrl_i.act == ACT_EMIT_OFF) && fire;

  // status for conditional jumps
  always_comb begin
    status_o.in_valid  = in_valid_i;
    status_o.is_cut    = item_q.mode;
    status_o.is_on     = (item_q.msg_type == TYPE_NOTE_ON) && (item_q.data_two != 7'd0);
    status_o.is_off    = (item_q.msg_type == TYPE_NOTE_OFF) ||
                         ((item_q.msg_type == TYPE_NOTE_ON) && (item_q.data_two == 7'd0));
    status_o.out_free  = out_free;
    status_o.full      = (count_q == CNT_W'(SLOT_COUNT));
    status_o.slot_free = !busy_q[idx];
    status_o.slot_busy = busy_q[idx];
    status_o.idx_end   = (idx_q == CNT_W'(SLOT_COUNT));
    status_o.match     = busy_q[idx] && (rd_q.chan == item_q.msg_channel) &&
                         (rd_q.note == item_q.data_one);
    status_o.none_busy = (count_q == '0);
  end

  always_comb begin
    ovf_d       = ovf_q;
    idx_d       = idx_q;
    count_d     = count_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    unique case (ctrl_i.act)
      ACT_LOAD: begin
        if (fire) begin
          ovf_d = 1'b0;
          idx_d = '0;
        end
      end
      ACT_SET_OVF: begin
        if (fire) begin
          ovf_d = 1'b1;
        end
      end
      ACT_TAKE: begin
        if (fire) begin
          busy_d[idx] = 1'b1;
          count_d     = count_q + CNT_W'(1);
        end else begin
          idx_d = idx_q + CNT_W'(1);
        end
      end
      ACT_OFF_CMP: begin
        if (fire) begin
          busy_d[idx] = 1'b0;
          count_d     = count_q - CNT_W'(1);
        end else begin
          idx_d = idx_q + CNT_W'(1);
        end
      end
      ACT_SCAN: begin
        if (!fire) begin
          idx_d = idx_q + CNT_W'(1);
        end
      end
      ACT_EMIT_PASS: begin
        if (fire) begin
          out_valid_d          = 1'b1;
          out_d.status_byte    = {item_q.msg_type, item_q.msg_channel};
          out_d.out_data_one   = item_q.data_one;
          out_d.out_data_two   = item_q.data_two;
          out_d.msg_length     = LEN_FULL;
          out_d.table_overflow = ovf_q;
          out_d.last_result    = 1'b1;
          if (item_q.msg_type == TYPE_PROGRAM || item_q.msg_type == TYPE_PRESSURE) begin
            out_d.out_data_two = 7'd0;
            out_d.msg_length   = LEN_SHORT;
          end
        end
      end
      ACT_EMIT_OFF: begin
        if (fire) begin
          out_valid_d          = 1'b1;
          out_d.status_byte    = {TYPE_NOTE_OFF, rd_q.chan};
          out_d.out_data_one   = rd_q.note;
          out_d.out_data_two   = 7'd0;
          out_d.msg_length     = LEN_FULL;
          out_d.table_overflow = 1'b0;
          out_d.last_result    = (count_q == CNT_W'(1));
          busy_d[idx]          = 1'b0;
          count_d              = count_q - CNT_W'(1);
          idx_d                = idx_q + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      count_q     <= '0;
      busy_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ovf_q       <= ovf_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (load_fire) begin
      item_q <= item_i;
    end
  end

  // slot memory, one write port, registered read at the scan index
  always_ff @(posedge clk_i) begin
    if (take_fire) begin
      slot_mem_q[idx] <= '{chan: item_q.msg_channel, note: item_q.data_one};
    end
    rd_q <= slot_mem_q[idx];
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

  a_count_tracks_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(busy_q) == int'(count_q))
    else $error("busy count out of step with busy bits");

  a_take_counts_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_fire |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("slot take did not bump the busy count");

  a_last_off_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_off_fire && count_q == CNT_W'(1)) |=> (count_q == '0 && busy_q == '0))
    else $error("table not empty after final generated note-off");

endmodule

// ===== rtl/midi_active_note_tracker_unit.sv =====
`timescale 1ns / 1ps
// A message word passes through the dispatch steps and the pass step; a note-on scans the
// busy bits one slot a cycle, a note-off alternates a read step and a compare step for each
// slot against the registered read of the slot memory, and a cut-all steps past idle slots
// and emits a note-off for each busy slot, waiting on output stalls. One microprogram step
// runs per cycle and a new word is taken only when the program is back at its idle step; a
// finished result waits in the output register meanwhile. No clearing pass is needed after
// reset.
// top level; depends on mant_pkg, mant_seq and mant_dp
module midi_active_note_tracker_unit #(
  parameter int SLOT_COUNT = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // msg_type[3:0], msg_channel[7:4], data_one[14:8], data_two[21:15], zero[23:22]
  input  logic [mant_pkg::TDATA_W-1:0] s_axis_tdata_i,
  // mode[0]
  input  logic                         s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // status_byte[7:0], out_data_one[14:8], out_data_two[21:15], msg_length[23:22]
  output logic [mant_pkg::TDATA_W-1:0] m_axis_tdata_o,
  // table_overflow[0]
  output logic                         m_axis_tuser_o,
  output logic                         m_axis_tlast_o
);
  import mant_pkg::*;

  ctrl_t   ctrl;
  status_t status;
  item_t   item;
  result_t result;

  assign item.mode        = s_axis_tuser_i;
  assign item.msg_type    = s_axis_tdata_i[3:0];
  assign item.msg_channel = s_axis_tdata_i[7:4];
  assign item.data_one    = s_axis_tdata_i[14:8];
  assign item.data_two    = s_axis_tdata_i[21:15];

  mant_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  mant_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .in_valid_i  (s_axis_tvalid_i),
    .item_i      (item),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .result_o    (result),
    .status_o    (status)
  );

  assign s_axis_tready_o = ctrl.in_ready;
  assign m_axis_tdata_o  = {result.msg_length, result.out_data_two,
                            result.out_data_one, result.status_byte};
  assign m_axis_tuser_o  = result.table_overflow;
  assign m_axis_tlast_o  = result.last_result;

endmodule

// ===== sim/midi_active_note_tracker_unit_tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for midi_active_note_tracker_unit: directed and random note traffic
// checked word by word against a slot table kept in the bench, with random gaps and stalls
// depends on mant_pkg and midi_active_note_tracker_unit
module midi_active_note_tracker_unit_tb;
  import mant_pkg::*;

  localparam int   SLOTS       = 64;
  localparam logic CHANNEL_MSG = 1'b0;
  localparam logic CUT_ALL     = 1'b1;

  typedef struct packed {
    item_t      msg;
    logic [3:0] gap;
  } queued_word_t;

  logic               clk      = 1'b0;
  logic               rst_n    = 1'b0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata  = '0;
  logic               s_tuser  = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic               m_tuser;
  logic               m_tlast;

  midi_active_note_tracker_unit #(
    .SLOT_COUNT(SLOTS)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .m_axis_tlast_o (m_tlast)
  );

  initial forever #4 clk = ~clk;

  // slot table as the bench sees it
  logic        slot_used [SLOTS] = '{default: 1'b0};
  slot_entry_t slot_tab  [SLOTS];
  result_t     awaited_msgs[$];

  task automatic track_message(input item_t w);
    result_t r;
    int      last_busy;
    bit      done;
    last_busy = -1;
    done      = 1'b0;
    if (w.mode == CUT_ALL) begin
      for (int i = 0; i < SLOTS; i++) if (slot_used[i]) last_busy = i;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_used[i]) begin
          r.status_byte    = {TYPE_NOTE_OFF, slot_tab[i].chan};
          r.out_data_one   = slot_tab[i].note;
          r.out_data_two   = '0;
          r.msg_length     = LEN_FULL;
          r.table_overflow = 1'b0;
          r.last_result    = (i == last_busy);
          awaited_msgs.push_back(r);
          slot_used[i] = 1'b0;
        end
      end
    end else begin
      r.status_byte    = {w.msg_type, w.msg_channel};
      r.out_data_one   = w.data_one;
      r.out_data_two   = w.data_two;
      r.msg_length     = LEN_FULL;
      r.table_overflow = 1'b0;
      r.last_result    = 1'b1;
      if (w.msg_type == TYPE_PROGRAM || w.msg_type == TYPE_PRESSURE) begin
        r.msg_length   = LEN_SHORT;
        r.out_data_two = '0;
      end
      if (w.msg_type == TYPE_NOTE_ON && w.data_two != '0) begin
        r.table_overflow = 1'b1;
        for (int i = 0; i < SLOTS; i++) begin
          if (!done && !slot_used[i]) begin
            slot_used[i]     = 1'b1;
            slot_tab[i]      = {w.msg_channel, w.data_one};
            r.table_overflow = 1'b0;
            done             = 1'b1;
          end
        end
      end else if (w.msg_type == TYPE_NOTE_OFF || w.msg_type == TYPE_NOTE_ON) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!done && slot_used[i] && slot_tab[i].chan == w.msg_channel &&
              slot_tab[i].note == w.data_one) begin
            slot_used[i] = 1'b0;
            done         = 1'b1;
          end
        end
      end
      awaited_msgs.push_back(r);
    end
  endtask

  function automatic string fmt_msg(input result_t r);
    return $sformatf("st=%h d1=%h d2=%h len=%0d ovf=%b last=%b", r.status_byte,
                     r.out_data_one, r.out_data_two, r.msg_length, r.table_overflow,
                     r.last_result);
  endfunction

  // input side
  queued_word_t word_fifo[$];
  item_t        on_bus;
  int unsigned  src_wait  = 0;
  bit           gap_armed = 1'b0;
  int unsigned  taken     = 0;

  always @(posedge clk or negedge rst_n) begin
    queued_word_t nxt;
    if (!rst_n) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        track_message(on_bus);
        taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (word_fifo.size() == 0) begin
          s_tvalid <= 1'b0;
        end else begin
          if (!gap_armed) begin
            src_wait  = word_fifo[0].gap;
            gap_armed = 1'b1;
          end
          if (src_wait != 0) begin
            src_wait--;
            s_tvalid <= 1'b0;
          end else begin
            nxt       = word_fifo.pop_front();
            on_bus    = nxt.msg;
            gap_armed = 1'b0;
            s_tvalid <= 1'b1;
            s_tdata  <= {2'b00, nxt.msg.data_two, nxt.msg.data_one, nxt.msg.msg_channel,
                         nxt.msg.msg_type};
            s_tuser  <= nxt.msg.mode;
          end
        end
      end
    end
  end

  // output side
  int unsigned snk_wait = 0;
  bit          snk_calm = 1'b0;
  int          errors   = 0;

  always @(posedge clk or negedge rst_n) begin
    result_t     got;
    result_t     want;
    int unsigned n;
    if (!rst_n) begin
      m_tready <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      got = {m_tdata[7:0], m_tdata[14:8], m_tdata[21:15], m_tdata[23:22], m_tuser, m_tlast};
      if (awaited_msgs.size() == 0) begin
        errors++;
        $display("%0t: expected nothing, got %s", $time, fmt_msg(got));
      end else begin
        want = awaited_msgs.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: expected %s, got %s", $time, fmt_msg(want), fmt_msg(got));
        end
      end
      if ($urandom_range(0, 31) == 0) snk_calm = !snk_calm;
      n        = snk_calm ? 0 : $urandom_range(0, 15);
      snk_wait = n;
      m_tready <= (n == 0);
    end else if (snk_wait != 0) begin
      snk_wait--;
      m_tready <= (snk_wait == 0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // stimulus
  bit          src_calm = 1'b0;
  slot_entry_t sounding[$];

  task automatic send(input logic mode, input logic [3:0] kind, input logic [3:0] ch,
                      input logic [6:0] d1, input logic [6:0] d2);
    queued_word_t q;
    int           hit;
    q.msg = {mode, kind, ch, d1, d2};
    q.gap = src_calm ? 4'd0 : 4'($urandom_range(0, 15));
    word_fifo.push_back(q);
    hit = -1;
    if (mode == CUT_ALL) begin
      sounding.delete();
    end else if (kind == TYPE_NOTE_ON && d2 != '0) begin
      sounding.push_back({ch, d1});
    end else if (kind == TYPE_NOTE_OFF || kind == TYPE_NOTE_ON) begin
      for (int i = 0; i < sounding.size(); i++)
        if (hit < 0 && sounding[i].chan == ch && sounding[i].note == d1) hit = i;
      if (hit >= 0) sounding.delete(hit);
    end
  endtask

  task automatic release_sounding();
    slot_entry_t e;
    e = sounding[$urandom_range(0, sounding.size() - 1)];
    if ($urandom_range(0, 1) == 0)
      send(CHANNEL_MSG, TYPE_NOTE_OFF, e.chan, e.note, 7'($urandom_range(0, 127)));
    else
      send(CHANNEL_MSG, TYPE_NOTE_ON, e.chan, e.note, 7'd0);
  endtask

  task automatic play_phrase(input int len);
    logic [3:0] ch;
    int         base;
    int         pick;
    ch   = 4'($urandom_range(0, 15));
    base = $urandom_range(0, 120);
    repeat (len) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send(CHANNEL_MSG, TYPE_NOTE_ON,
             ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : ch,
             7'(base + $urandom_range(0, 7)), 7'($urandom_range(1, 127)));
      end else if (pick < 75 && sounding.size() != 0) begin
        release_sounding();
      end else if (pick < 85) begin
        send(CHANNEL_MSG, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
             7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
      end else if (pick < 95) begin
        send(CHANNEL_MSG, ($urandom_range(0, 1) == 0) ? TYPE_PROGRAM : TYPE_PRESSURE, ch,
             7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
      end else begin
        send(CUT_ALL, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
             7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
      end
    end
    if ($urandom_range(0, 2) == 0)
      send(CUT_ALL, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
           7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
  endtask

  // fill every slot, overflow, punch a few holes, refill and cut
  task automatic fill_table();
    repeat (SLOTS + 3)
      send(CHANNEL_MSG, TYPE_NOTE_ON, 4'($urandom_range(0, 15)), 7'($urandom_range(0, 127)),
           ($urandom_range(0, 7) == 0) ? 7'h7f : 7'($urandom_range(1, 127)));
    repeat (4) release_sounding();
    repeat (6)
      send(CHANNEL_MSG, TYPE_NOTE_ON, 4'($urandom_range(0, 15)), 7'($urandom_range(0, 127)),
           7'($urandom_range(1, 127)));
    send(CUT_ALL, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
         7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
  endtask

  initial begin
    logic [3:0] kind;
    int         total_words;
    bit         filled;
    filled = 1'b0;

    send(CHANNEL_MSG, TYPE_NOTE_OFF, 4'h0, 7'h00, 7'h00);  // nothing to free
    send(CHANNEL_MSG, TYPE_NOTE_ON, 4'hf, 7'h7f, 7'h7f);
    send(CHANNEL_MSG, TYPE_NOTE_ON, 4'h0, 7'h00, 7'h01);
    send(CHANNEL_MSG, TYPE_NOTE_ON, 4'hf, 7'h7f, 7'h40);   // same note twice
    send(CHANNEL_MSG, TYPE_NOTE_ON, 4'he, 7'h7f, 7'h00);   // wrong channel, no match
    send(CHANNEL_MSG, TYPE_NOTE_ON, 4'hf, 7'h7f, 7'h00);   // frees the lower copy
    send(CHANNEL_MSG, TYPE_PROGRAM, 4'h5, 7'h7f, 7'h7f);
    send(CHANNEL_MSG, TYPE_PRESSURE, 4'ha, 7'h00, 7'h7f);
    for (int t = 0; t < 16; t++) begin
      kind = 4'(t);
      if (kind != TYPE_NOTE_OFF && kind != TYPE_NOTE_ON && kind != TYPE_PROGRAM &&
          kind != TYPE_PRESSURE)
        send(CHANNEL_MSG, kind, ~kind, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
    end
    send(CUT_ALL, 4'hf, 4'hf, 7'h7f, 7'h7f);               // two sounding notes
    send(CHANNEL_MSG, TYPE_NOTE_OFF, 4'h0, 7'h00, 7'h7f);
    send(CUT_ALL, 4'h0, 4'h0, 7'h00, 7'h00);               // empty table, no word back
    send(CHANNEL_MSG, TYPE_NOTE_ON, 4'h3, 7'h3c, 7'h64);
    send(CUT_ALL, 4'h9, 4'h3, 7'h3c, 7'h00);

    while (word_fifo.size() < 270) begin
      src_calm = ($urandom_range(0, 3) == 0);
      if (!filled && word_fifo.size() > 120) begin
        fill_table();
        filled = 1'b1;
      end else begin
        play_phrase($urandom_range(4, 20));
      end
    end
    src_calm    = 1'b0;
    total_words = word_fifo.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (taken != total_words) @(posedge clk);
    while (awaited_msgs.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== midi_active_note_tracker_unit.f =====
rtl/mant_pkg.sv
rtl/mant_seq.sv
rtl/mant_dp.sv
rtl/midi_active_note_tracker_unit.sv
sim/midi_active_note_tracker_unit_tb.sv
